>>> hw/rtl/mm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types and constants of the matrix multiply unit.
// ----------------------------------------------------------------------------
package mm_pkg;

    localparam int MAX_DIM = 8;
    localparam int DIM_W   = 3;                 // row and column fields
    localparam int CNT_W   = DIM_W + 1;         // holds the dimension itself
    localparam int ADDR_W  = 2 * DIM_W;
    localparam int CELLS   = 1 << ADDR_W;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int ACC_W   = 35;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [OP_W-1:0] OP_WR_LEFT  = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_RIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_MULTIPLY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS    = 2'd2;

    localparam logic [CNT_W-1:0] DIM_MAX = CNT_W'(MAX_DIM);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             wr_en;
        logic             rd_vld;
        logic             rd_first;
        logic             rd_last;
        logic             rd_zero;
        logic [DIM_W-1:0] rd_row;
        logic [DIM_W-1:0] rd_k;
        logic [DIM_W-1:0] rd_col;
        logic             out_load;
        logic [DIM_W-1:0] out_row;
        logic [DIM_W-1:0] out_col;
        logic             out_last;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] m_eff;
        logic [CNT_W-1:0] n_eff;
        logic [CNT_W-1:0] p_eff;
        logic             acc_done;
        logic             out_free;
    } t_status;

    function automatic logic [CNT_W-1:0] sat_dim(input logic [CFG_DATA_W-1:0] v);
        logic [CNT_W-1:0] x;
        x = CNT_W'(v);
        return (x > DIM_MAX) ? DIM_MAX : x;
    endfunction

endpackage

>>> hw/rtl/mm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_ctrl
// Sequencer: accepts requests, walks rows, columns and the inner index,
// and hands finished elements to the output register.
// ----------------------------------------------------------------------------
module mm_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  logic [mm_pkg::OP_W-1:0] i_req_op,
    output logic                   o_req_ready,
    input  mm_pkg::t_status        i_status,
    output mm_pkg::t_cmd           o_cmd
);
    import mm_pkg::*;

    t_state           r_state, n_state;
    logic [DIM_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] r_col, n_col;
    logic [DIM_W-1:0] r_k, n_k;

    logic [CNT_W-1:0] k_cnt;
    logic             k_last;
    logic             row_last;
    logic             col_last;
    logic             empty;

    assign k_cnt    = (i_status.n_eff == '0) ? CNT_W'(1) : i_status.n_eff;
    assign k_last   = (CNT_W'(r_k) + CNT_W'(1)) >= k_cnt;
    assign row_last = (CNT_W'(r_row) + CNT_W'(1)) == i_status.m_eff;
    assign col_last = (CNT_W'(r_col) + CNT_W'(1)) == i_status.p_eff;
    assign empty    = (i_status.m_eff == '0) || (i_status.p_eff == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_k         = r_k;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        o_cmd.rd_row   = r_row;
        o_cmd.rd_col   = r_col;
        o_cmd.rd_k     = r_k;
        o_cmd.rd_first = (r_k == '0);
        o_cmd.rd_last  = k_last;
        o_cmd.rd_zero  = (i_status.n_eff == '0);
        o_cmd.out_row  = r_row;
        o_cmd.out_col  = r_col;
        o_cmd.out_last = row_last && col_last;

        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.wr_en = i_req_valid;
                if (i_req_valid && (i_req_op == OP_MULTIPLY) && !empty) begin
                    n_row   = '0;
                    n_col   = '0;
                    n_k     = '0;
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                o_cmd.rd_vld = 1'b1;
                if (k_last) begin
                    n_k     = '0;
                    n_state = ST_WAIT;
                end else begin
                    n_k = r_k + DIM_W'(1);
                end
            end
            ST_WAIT: begin
                if (i_status.acc_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (row_last && col_last) begin
                        n_state = ST_IDLE;
                    end else if (col_last) begin
                        n_col   = '0;
                        n_row   = r_row + DIM_W'(1);
                        n_state = ST_ISSUE;
                    end else begin
                        n_col   = r_col + DIM_W'(1);
                        n_state = ST_ISSUE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/mm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_dp
// Datapath: dimension registers, element stores, pipelined multiply
// accumulate and the result register.
// ----------------------------------------------------------------------------
module mm_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [mm_pkg::OP_W-1:0]       i_op,
    input  logic [mm_pkg::DIM_W-1:0]      i_row,
    input  logic [mm_pkg::DIM_W-1:0]      i_col,
    input  logic signed [mm_pkg::VAL_W-1:0] i_value,
    input  mm_pkg::t_cmd                  i_cmd,
    output mm_pkg::t_status               o_status,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [mm_pkg::DIM_W-1:0]      o_out_row,
    output logic [mm_pkg::DIM_W-1:0]      o_out_col,
    output logic signed [mm_pkg::ACC_W-1:0] o_out_product,
    output logic                          o_out_last
);
    import mm_pkg::*;

    logic [CFG_DATA_W-1:0] r_a_rows;
    logic [CFG_DATA_W-1:0] r_inner_dim;
    logic [CFG_DATA_W-1:0] r_b_cols;
    logic [CNT_W-1:0]      m_eff, n_eff, p_eff;

    logic signed [VAL_W-1:0] r_left  [CELLS];
    logic signed [VAL_W-1:0] r_right [CELLS];

    logic signed [VAL_W-1:0]  r_a_q, r_b_q;
    logic                     r_s1_vld, r_s1_first, r_s1_last, r_s1_zero;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] prod_raw;
    logic                     r_s2_vld, r_s2_first, r_s2_last;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic                     r_acc_done;

    logic                     r_out_vld;
    logic [DIM_W-1:0]         r_out_row, r_out_col;
    logic signed [ACC_W-1:0]  r_out_prod;
    logic                     r_out_last;

    logic                     wr_left, wr_right;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [ACC_W-1:0]  prod_ext;

    assign m_eff = sat_dim(r_a_rows);
    assign n_eff = sat_dim(r_inner_dim);
    assign p_eff = sat_dim(r_b_cols);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows    <= CFG_DATA_W'(MAX_DIM);
            r_inner_dim <= CFG_DATA_W'(MAX_DIM);
            r_b_cols    <= CFG_DATA_W'(MAX_DIM);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_A_ROWS:    r_a_rows    <= i_cfg_data;
                CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                CFG_B_COLS:    r_b_cols    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // element stores
    assign wr_addr  = {i_row, i_col};
    assign wr_left  = i_cmd.wr_en && (i_op == OP_WR_LEFT)
                      && (CNT_W'(i_row) < m_eff) && (CNT_W'(i_col) < n_eff);
    assign wr_right = i_cmd.wr_en && (i_op == OP_WR_RIGHT)
                      && (CNT_W'(i_row) < n_eff) && (CNT_W'(i_col) < p_eff);

    always_ff @(posedge i_clk) begin
        if (wr_left) begin
            r_left[wr_addr] <= i_value;
        end
        if (wr_right) begin
            r_right[wr_addr] <= i_value;
        end
        r_a_q <= r_left[{i_cmd.rd_row, i_cmd.rd_k}];
        r_b_q <= r_right[{i_cmd.rd_k, i_cmd.rd_col}];
    end

    // multiply stage
    assign prod_raw = r_a_q * r_b_q;

    always_ff @(posedge i_clk) begin
        r_prod <= r_s1_zero ? '0 : prod_raw;
        r_s1_first <= i_cmd.rd_first;
        r_s1_last  <= i_cmd.rd_last;
        r_s1_zero  <= i_cmd.rd_zero;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
    end

    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign n_acc    = r_s2_first ? prod_ext : r_acc + prod_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_acc      <= '0;
            r_acc_done <= 1'b0;
        end else begin
            r_s1_vld   <= i_cmd.rd_vld;
            r_s2_vld   <= r_s1_vld;
            r_acc_done <= r_s2_vld && r_s2_last;
            if (r_s2_vld) begin
                r_acc <= n_acc;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_row  <= i_cmd.out_row;
            r_out_col  <= i_cmd.out_col;
            r_out_prod <= r_acc;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_status.m_eff    = m_eff;
    assign o_status.n_eff    = n_eff;
    assign o_status.p_eff    = p_eff;
    assign o_status.acc_done = r_acc_done;
    assign o_status.out_free = !r_out_vld || i_out_ready;

    assign o_out_valid   = r_out_vld;
    assign o_out_row     = r_out_row;
    assign o_out_col     = r_out_col;
    assign o_out_product = r_out_prod;
    assign o_out_last    = r_out_last;

endmodule

>>> hw/rtl/matrix_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply
// Dense product C = A x B of signed Q8.8 matrices up to 8 x 8, exact Q19.16.
// ----------------------------------------------------------------------------
// usage
//   s_axis request: tuser = opcode (write A, write B, multiply), tdata holds
//   row, column and value. writes are accepted back to back while idle and
//   are dropped when outside the configured dimensions.
//   a multiply request streams every element of C on m_axis in row-major
//   order, tlast on the final one; s_axis_tready stays low until the last
//   element is in the result register.
//   per element, one shared multiply-accumulate reads one A and one B entry
//   per cycle over inner_dim, through store read, multiply, accumulate and
//   handoff stages; the next element is issued only after the previous one
//   is loaded into the result register.
//   cfg channel writes a_rows, inner_dim, b_cols (values above 8 act as 8),
//   always ready; write it only while idle.
//   reset: dimensions return to 8, no result pending; store contents are
//   undefined until written.
//   a stalled receiver holds the result register; the unit computes the next
//   element meanwhile and waits to hand it over.
// ----------------------------------------------------------------------------
module matrix_multiply (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // row, col, value, pad
    input  logic [mm_pkg::OP_W-1:0]          s_axis_tuser,   // opcode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [mm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // out_row, out_col, product, pad
    output logic                             m_axis_tlast
);
    import mm_pkg::*;

    t_cmd                    cmd;
    t_status                 status;
    logic [DIM_W-1:0]        out_row, out_col;
    logic signed [ACC_W-1:0] out_prod;

    assign o_cfg_ready = 1'b1;

    mm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_op    (s_axis_tuser),
        .o_req_ready (s_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_op          (s_axis_tuser),
        .i_row         (s_axis_tdata[DIM_W-1:0]),
        .i_col         (s_axis_tdata[2*DIM_W-1:DIM_W]),
        .i_value       (s_axis_tdata[2*DIM_W+VAL_W-1:2*DIM_W]),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_row     (out_row),
        .o_out_col     (out_col),
        .o_out_product (out_prod),
        .o_out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {(OUT_TDATA_W-2*DIM_W-ACC_W)'(0), out_prod, out_col, out_row};

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result register overwritten while pending");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.acc_done |-> !s_axis_tready)
        else $error("accumulation finished while idle");

    a_issue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_vld |-> (({1'b0, cmd.rd_row} < status.m_eff)
                        && ({1'b0, cmd.rd_col} < status.p_eff)))
        else $error("store read outside result dimensions");
`endif

endmodule

>>> bench/matrix_multiply_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_tb
// Self-checking bench for the matrix multiply unit. A request queue feeds a
// stream driver, and a tracking model of both stores and the dimension
// registers predicts every element of C on each multiply. A monitor compares
// the result stream field by field. The run covers directed extremes, several
// dimension settings (zero, saturating and random among them), random
// element writes with stray and unused requests, stalls on both sides and one
// long receiver hold-off.
// ----------------------------------------------------------------------------
module matrix_multiply_tb;
    import mm_pkg::*;

    localparam logic [OP_W-1:0]      OP_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
    localparam int                   PHASE_ITEMS = 18;
    localparam int                   HOLD_CYCLES = 400;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic [DIM_W-1:0]         row;
        logic [DIM_W-1:0]         col;
        logic signed [VAL_W-1:0]  value;
    } t_request;

    typedef struct {
        logic [DIM_W-1:0]         row;
        logic [DIM_W-1:0]         col;
        logic signed [ACC_W-1:0]  product;
        logic                     last;
    } t_element;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [IN_TDATA_W-1:0]      s_axis_tdata = '0;   // row, col, value, pad
    logic [OP_W-1:0]            s_axis_tuser = '0;   // opcode
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;        // out_row, out_col, product, pad
    logic                       m_axis_tlast;

    matrix_multiply dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // dimension registers as the unit should hold them
    logic [CFG_DATA_W-1:0]      dim_a_rows = 4'd8;
    logic [CFG_DATA_W-1:0]      dim_inner = 4'd8;
    logic [CFG_DATA_W-1:0]      dim_b_cols = 4'd8;

    logic signed [VAL_W-1:0]    left_mem [CELLS];
    logic signed [VAL_W-1:0]    right_mem [CELLS];
    bit                         left_filled [CELLS];
    bit                         right_filled [CELLS];

    t_request                   req_q [$];
    t_element                   product_q [$];
    t_request                   cur_req;
    int unsigned                issued_cnt = 0;
    int unsigned                taken_cnt = 0;
    int unsigned                live_cnt = 0;
    int unsigned                mismatch_cnt = 0;
    int unsigned                send_gap = 0;
    int unsigned                recv_gap = 0;
    int unsigned                hold_left = 0;
    bit                         hold_armed = 1'b0;
    bit                         hold_on = 1'b0;
    bit                         hold_done = 1'b0;
    bit                         calm = 1'b0;

    function automatic int eff_dim(logic [CFG_DATA_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // tracking model: updates the stores, or expands a multiply into C
    function automatic void apply_request(t_request rq);
        int m, n, p;
        logic signed [ACC_W-1:0] acc;
        t_element el;
        m = eff_dim(dim_a_rows);
        n = eff_dim(dim_inner);
        p = eff_dim(dim_b_cols);
        case (rq.op)
            OP_WR_LEFT: begin
                if (rq.row < m && rq.col < n)
                    left_mem[{rq.row, rq.col}] = rq.value;
            end
            OP_WR_RIGHT: begin
                if (rq.row < n && rq.col < p)
                    right_mem[{rq.row, rq.col}] = rq.value;
            end
            OP_MULTIPLY: begin
                for (int r = 0; r < m; r++) begin
                    for (int c = 0; c < p; c++) begin
                        acc = '0;
                        for (int k = 0; k < n; k++)
                            acc += left_mem[r * MAX_DIM + k] * right_mem[k * MAX_DIM + c];
                        el.row = DIM_W'(r);
                        el.col = DIM_W'(c);
                        el.product = acc;
                        el.last = (r == m - 1) && (c == p - 1);
                        product_q.push_back(el);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_request(logic [OP_W-1:0] op, int row, int col,
                                          logic signed [VAL_W-1:0] value);
        t_request rq;
        int m, n, p;
        m = eff_dim(dim_a_rows);
        n = eff_dim(dim_inner);
        p = eff_dim(dim_b_cols);
        rq.op = op;
        rq.row = DIM_W'(row);
        rq.col = DIM_W'(col);
        rq.value = value;
        req_q.push_back(rq);
        if (op == OP_WR_LEFT && row < m && col < n) begin
            left_filled[row * MAX_DIM + col] = 1'b1;
            live_cnt++;
        end else if (op == OP_WR_RIGHT && row < n && col < p) begin
            right_filled[row * MAX_DIM + col] = 1'b1;
            live_cnt++;
        end else if (op == OP_MULTIPLY) begin
            live_cnt++;
        end
    endfunction

    // fill every entry the product will read that is not yet written, then multiply
    function automatic void queue_multiply();
        int m, n, p;
        m = eff_dim(dim_a_rows);
        n = eff_dim(dim_inner);
        p = eff_dim(dim_b_cols);
        for (int r = 0; r < m; r++)
            for (int k = 0; k < n; k++)
                if (!left_filled[r * MAX_DIM + k])
                    queue_request(OP_WR_LEFT, r, k, pick_value());
        for (int k = 0; k < n; k++)
            for (int c = 0; c < p; c++)
                if (!right_filled[k * MAX_DIM + c])
                    queue_request(OP_WR_RIGHT, k, c, pick_value());
        queue_request(OP_MULTIPLY, $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
    endfunction

    function automatic void note_mismatch(string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || taken_cnt == issued_cnt) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (req_q.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
                send_gap <= $urandom_range(1, 11) - 1;
                s_axis_tvalid <= 1'b0;
            end else if (req_q.size() != 0) begin
                cur_req = req_q.pop_front();
                s_axis_tdata <= {2'b00, cur_req.value, cur_req.col, cur_req.row};
                s_axis_tuser <= cur_req.op;
                s_axis_tvalid <= 1'b1;
                issued_cnt <= issued_cnt + 1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, started once a result is waiting
    always @(negedge i_clk) begin
        if (hold_on) begin
            if (hold_left == 1)
                hold_on <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_done && m_axis_tvalid) begin
            hold_on <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_on) begin
            m_axis_tready <= 1'b0;
        end else if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            recv_gap <= $urandom_range(1, 11) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        t_element want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            apply_request(cur_req);
            taken_cnt <= taken_cnt + 1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (product_q.size() == 0) begin
                note_mismatch($sformatf("unexpected element row %0d col %0d product %0d",
                    m_axis_tdata[2:0], m_axis_tdata[5:3], $signed(m_axis_tdata[40:6])));
            end else begin
                want = product_q.pop_front();
                if (m_axis_tdata[2:0] !== want.row || m_axis_tdata[5:3] !== want.col ||
                    m_axis_tdata[40:6] !== want.product || m_axis_tlast !== want.last)
                    note_mismatch($sformatf(
                        "expected row %0d col %0d product %0d last %0b, got %0d %0d %0d %0b",
                        want.row, want.col, want.product, want.last, m_axis_tdata[2:0],
                        m_axis_tdata[5:3], $signed(m_axis_tdata[40:6]), m_axis_tlast));
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_A_ROWS:    dim_a_rows = data;
            CFG_INNER_DIM: dim_inner = data;
            CFG_B_COLS:    dim_b_cols = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_dims(int a, int k, int b);
        write_reg(CFG_A_ROWS, CFG_DATA_W'(a));
        write_reg(CFG_INNER_DIM, CFG_DATA_W'(k));
        write_reg(CFG_B_COLS, CFG_DATA_W'(b));
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (req_q.size() != 0 || s_axis_tvalid || product_q.size() != 0);
        repeat (24) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic random_phase();
        int unsigned start;
        int m, n, p, pick;
        start = live_cnt;
        m = eff_dim(dim_a_rows);
        n = eff_dim(dim_inner);
        p = eff_dim(dim_b_cols);
        while (live_cnt - start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                queue_request(OP_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                              pick_value());
            else if (pick < 12)
                queue_request($urandom_range(0, 1) ? OP_WR_RIGHT : OP_WR_LEFT,
                              $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
            else if (pick < 27 || n == 0)
                queue_multiply();
            else if (pick < 63 && m > 0)
                queue_request(OP_WR_LEFT, $urandom_range(0, m - 1), $urandom_range(0, n - 1),
                              pick_value());
            else if (p > 0)
                queue_request(OP_WR_RIGHT, $urandom_range(0, n - 1), $urandom_range(0, p - 1),
                              pick_value());
            else
                queue_multiply();
        end
        queue_multiply();
        wait_idle();
    endtask

    initial begin
        int dims [10][3];
        dims = '{'{8, 8, 8}, '{1, 1, 1}, '{3, 5, 2}, '{8, 1, 8}, '{1, 8, 1},
                 '{0, 4, 4}, '{4, 0, 3}, '{15, 9, 12}, '{5, 7, 6}, '{8, 8, 8}};
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 2 x 2 x 2 with extreme values, stray and unused requests
        set_dims(2, 2, 2);
        queue_request(OP_WR_LEFT, 0, 0, 16'sh8000);
        queue_request(OP_WR_LEFT, 0, 1, 16'sh8000);
        queue_request(OP_WR_LEFT, 1, 0, 16'sh7fff);
        queue_request(OP_WR_LEFT, 1, 1, 16'sh7fff);
        queue_request(OP_WR_RIGHT, 0, 0, 16'sh8000);
        queue_request(OP_WR_RIGHT, 1, 0, 16'sh8000);
        queue_request(OP_WR_RIGHT, 0, 1, 16'sh7fff);
        queue_request(OP_WR_RIGHT, 1, 1, 16'sh7fff);
        queue_request(OP_MULTIPLY, 7, 7, 16'shffff);
        queue_request(OP_UNUSED, 5, 3, 16'sh1234);
        queue_request(OP_WR_LEFT, 7, 7, 16'sh0101);
        queue_request(OP_WR_RIGHT, 2, 0, 16'sh0202);
        queue_request(OP_WR_LEFT, 0, 1, 16'sh0000);
        queue_request(OP_MULTIPLY, 0, 0, 16'sh0000);
        queue_request(OP_WR_LEFT, 1, 1, 16'sh0001);
        queue_request(OP_WR_RIGHT, 1, 1, 16'shffff);
        queue_request(OP_MULTIPLY, 3, 4, 16'sh5555);
        wait_idle();

        // full-size product with every term at the negative extreme
        set_dims(8, 8, 8);
        for (int r = 0; r < MAX_DIM; r++)
            for (int c = 0; c < MAX_DIM; c++) begin
                queue_request(OP_WR_LEFT, r, c, 16'sh8000);
                queue_request(OP_WR_RIGHT, r, c, 16'sh8000);
            end
        queue_request(OP_MULTIPLY, 0, 0, 16'sh0000);
        wait_idle();

        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 7)
                write_reg(CFG_SPARE, 4'd5);
            if (ph == 8)
                set_dims($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8));
            else
                set_dims(dims[ph][0], dims[ph][1], dims[ph][2]);
            hold_armed = (ph == 0);
            calm = (ph == 9);
            random_phase();
        end

        if (mismatch_cnt == 0 && product_q.size() == 0)
            $display("matrix_multiply_tb: clean");
        else
            $display("matrix_multiply_tb: errors");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("matrix_multiply_tb: errors");
        $finish;
    end

endmodule

>>> matrix_multiply.f
hw/rtl/mm_pkg.sv
hw/rtl/mm_ctrl.sv
hw/rtl/mm_dp.sv
hw/rtl/matrix_multiply.sv
bench/matrix_multiply_tb.sv
